// ===== rtl/wtr_pkg.sv =====
// Shared types and constants for the waveform trace rasterizer.
// No dependencies; used by wtr_ctrl, wtr_dp and waveform_trace_rasterizer.
package wtr_pkg;

  localparam int SampleW = 16;
  localparam int ColW    = 10;
  localparam int ChanW   = 3;
  localparam int RowW    = 6;
  localparam int ColorW  = 8;
  localparam int HeightW = 7;
  localparam int DiffW   = 17;
  localparam int ProdW   = DiffW + HeightW;

  localparam int InDataW  = 32;
  localparam int OutDataW = 24;

  localparam logic [HeightW-1:0] HeightReset = 7'd64;
  localparam logic [ColorW-1:0]  ColorBase   = 8'd255;
  localparam logic [ColorW-1:0]  ColorStep   = 8'd50;

  // Controller to datapath
  typedef struct packed {
    logic load;   // capture accepted item
    logic calc;   // resolve target and start row
    logic step;   // move one row and fill output register
  } wtr_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic col_ok;     // incoming column lies inside the display
    logic step_last;  // the pending step lands on the target
  } wtr_sts_t;

  function automatic logic [ColorW-1:0] trace_color(input logic [ChanW-1:0] ch);
    logic [ColorW-1:0] prod;
    prod = ColorStep * {{(ColorW-ChanW){1'b0}}, ch};
    return ColorBase - prod;
  endfunction

endpackage

// ===== rtl/wtr_ctrl.sv =====
// Sequencer for the trace rasterizer: accept, resolve target, emit pixels.
// Depends on wtr_pkg for the command and status structs.
module wtr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  input  wtr_pkg::wtr_sts_t sts,
  output wtr_pkg::wtr_cmd_t cmd
);
  import wtr_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CALC = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       slot_free;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign slot_free  = !out_valid_r || out_tready;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_tready;
    cmd           = '0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load = 1'b1;
          // drop items whose column is off the display
          if (sts.col_ok) state_nxt = S_CALC;
        end
      end
      S_CALC: begin
        cmd.calc  = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (slot_free) begin
          cmd.step      = 1'b1;
          out_valid_nxt = 1'b1;
          if (sts.step_last) state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== rtl/wtr_dp.sv =====
// Datapath of the trace rasterizer: height register, target multiply,
// row stepper and output register. Depends on wtr_pkg.
module wtr_dp #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [wtr_pkg::InDataW-1:0]   in_tdata,
  input  logic [wtr_pkg::ChanW-1:0]     in_tuser,
  input  logic                          cfg_valid,
  input  logic [wtr_pkg::HeightW-1:0]   cfg_data,
  input  wtr_pkg::wtr_cmd_t             cmd,
  output wtr_pkg::wtr_sts_t             sts,
  output logic [wtr_pkg::OutDataW-1:0]  out_tdata,
  output logic                          out_tlast
);
  import wtr_pkg::*;

  logic [HeightW-1:0] height_r;
  logic [HeightW-1:0] h_eff;
  logic [SampleW-1:0] sample;
  logic [ColW-1:0]    column;
  logic [DiffW-1:0]   diff;

  logic [ProdW-1:0]   prod_r;
  logic [HeightW-1:0] h_r;
  logic [ColW-1:0]    col_r;
  logic [ColorW-1:0]  color_r;

  logic [ProdW-DiffW:0] v_full;
  logic [RowW-1:0]      v_clamped;
  logic [RowW-1:0]      v_r;
  logic [RowW-1:0]      y_r;
  logic [RowW-1:0]      y_step;

  logic [RowW-1:0]   out_row_r;
  logic [ColW-1:0]   out_col_r;
  logic [ColorW-1:0] out_color_r;
  logic              out_last_r;

  assign sample = in_tdata[SampleW-1:0];
  assign column = in_tdata[SampleW +: ColW];

  // zero height acts as one row, oversize saturates
  always_comb begin
    if (height_r == '0) begin
      h_eff = HeightW'(1);
    end else if (height_r > HeightW'(MAX_HEIGHT)) begin
      h_eff = HeightW'(MAX_HEIGHT);
    end else begin
      h_eff = height_r;
    end
  end

  // 32768 - sample, always 1..65536
  assign diff = DiffW'(32768) - {sample[SampleW-1], sample};

  assign sts.col_ok = ({{(32-ColW){1'b0}}, column} < 32'(MAX_WIDTH));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      height_r <= HeightReset;
    end else if (cfg_valid) begin
      height_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      prod_r  <= ProdW'(diff) * ProdW'(h_eff);
      h_r     <= h_eff;
      col_r   <= column;
      color_r <= trace_color(in_tuser);
    end
  end

  assign v_full    = prod_r[ProdW-1:DiffW-1];
  assign v_clamped = (v_full >= {1'b0, h_r}) ? RowW'(h_r - HeightW'(1)) : RowW'(v_full);

  always_comb begin
    if (y_r < v_r) begin
      y_step = y_r + RowW'(1);
    end else if (y_r > v_r) begin
      y_step = y_r - RowW'(1);
    end else begin
      y_step = y_r;
    end
  end

  assign sts.step_last = (y_step == v_r);

  // y_r doubles as the previous row between items
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      y_r <= '0;
    end else if (cmd.calc) begin
      if (col_r == '0) y_r <= v_clamped;
    end else if (cmd.step) begin
      y_r <= y_step;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.calc) v_r <= v_clamped;
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      out_row_r   <= y_step;
      out_col_r   <= col_r;
      out_color_r <= color_r;
      out_last_r  <= sts.step_last;
    end
  end

  assign out_tdata = {out_color_r, out_col_r, out_row_r};
  assign out_tlast = out_last_r;

endmodule

// ===== rtl/waveform_trace_rasterizer.sv =====
// Top level of the waveform trace rasterizer.
// Depends on wtr_pkg, wtr_ctrl and wtr_dp.
//
//   channel  dir  handshake             payload
//   in_      in   in_tvalid/in_tready   tdata: sample, column; tuser: channel
//   out_     out  out_tvalid/out_tready tdata: row, column, color; tlast: last
//   cfg_     in   cfg_valid/cfg_ready   cfg_data: display_height
//
// An accepted sample first resolves its target row (multiply, then clamp),
// then emits one pixel per cycle while the output is not stalled: 1 to 63
// pixel transfers per item, from the single row stepper. A column outside
// the display is consumed with no output. out_tready low holds the stepper.
// rst_n is synchronous; after reset the height is 64 and the trace starts
// at row 0. Configuration is always ready.
module waveform_trace_rasterizer #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [wtr_pkg::InDataW-1:0]   in_tdata,   // [15:0] sample, [25:16] column
  input  logic [wtr_pkg::ChanW-1:0]     in_tuser,   // [2:0] channel
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [wtr_pkg::OutDataW-1:0]  out_tdata,  // [5:0] row, [15:6] column, [23:16] color
  output logic                          out_tlast,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [wtr_pkg::HeightW-1:0]   cfg_data
);
  import wtr_pkg::*;

  wtr_cmd_t cmd;
  wtr_sts_t sts;

  assign cfg_ready = 1'b1;

  wtr_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  wtr_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

endmodule

// ===== tb/wtr_trace_checker.sv =====
// Scoreboard for the waveform trace rasterizer: watches the sample, pixel and height channels.
// Predicts every pixel write on its own and compares each one as it leaves the block.
// Depends on wtr_pkg for port widths.
module wtr_trace_checker #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  input  logic                          in_tready,
  input  logic [wtr_pkg::InDataW-1:0]   in_tdata,   // [15:0] sample, [25:16] column
  input  logic [wtr_pkg::ChanW-1:0]     in_tuser,   // [2:0] channel
  input  logic                          out_tvalid,
  input  logic                          out_tready,
  input  logic [wtr_pkg::OutDataW-1:0]  out_tdata,  // [5:0] row, [15:6] column, [23:16] color
  input  logic                          out_tlast,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [wtr_pkg::HeightW-1:0]   cfg_data,
  output int                            error_count,
  output int                            pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import wtr_pkg::*;

  localparam int ColorTop   = 255;
  localparam int ColorPitch = 50;
  localparam int MaxSteps   = 64;
  localparam int FullScale  = 32768;
  localparam int ReportMax  = 10;

  typedef struct packed {
    logic [RowW-1:0]   row;
    logic [ColW-1:0]   column;
    logic [ColorW-1:0] color;
    logic              last;
  } pixel_write_t;

  pixel_write_t             pixel_writes_due[$];
  logic [HeightW-1:0]       height_setting = HeightReset;
  int unsigned              trace_row      = 0;
  int                       failures       = 0;
  int                       due_count      = 0;

  assign error_count = failures;
  assign pending     = due_count;

  // Walk the trace from the last row toward this sample's row, one pixel per move.
  task automatic rasterize_sample(input logic signed [SampleW-1:0] sample,
                                  input logic [ColW-1:0] column,
                                  input logic [ChanW-1:0] chan);
    int unsigned  rows;
    int unsigned  level;
    int unsigned  target;
    int unsigned  row;
    int           steps;
    pixel_write_t px;
    if (int'(column) >= MAX_WIDTH) return;
    rows = height_setting;
    if (rows < 1) rows = 1;
    if (rows > MAX_HEIGHT) rows = MAX_HEIGHT;
    level  = FullScale - int'(sample);
    target = (level * rows) >> 16;
    if (target > rows - 1) target = rows - 1;
    row   = (column == '0) ? target : trace_row;
    steps = 0;
    do begin
      if (row < target) row++;
      else if (row > target) row--;
      px.row    = RowW'(row);
      px.column = column;
      px.color  = ColorW'(ColorTop - ColorPitch * int'(chan));
      px.last   = (row == target);
      pixel_writes_due.push_back(px);
      steps++;
    end while (row != target && steps < MaxSteps);
    trace_row = target;
  endtask

  always @(posedge clk) begin : watch
    pixel_write_t got;
    pixel_write_t want;
    if (!rst_n) begin
      pixel_writes_due.delete();
      height_setting = HeightReset;
      trace_row      = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.row    = out_tdata[RowW-1:0];
        got.column = out_tdata[RowW +: ColW];
        got.color  = out_tdata[RowW+ColW +: ColorW];
        got.last   = out_tlast;
        if (pixel_writes_due.size() == 0) begin
          failures++;
          if (failures <= ReportMax)
            $display("unexpected pixel transfer: row %0d col %0d color %0d last %0b",
                     got.row, got.column, got.color, got.last);
        end else begin
          want = pixel_writes_due.pop_front();
          if (got.row !== want.row || got.column !== want.column ||
              got.color !== want.color || got.last !== want.last) begin
            failures++;
            if (failures <= ReportMax)
              $display("pixel mismatch: expected row %0d col %0d color %0d last %0b, %s",
                       want.row, want.column, want.color, want.last,
                       $sformatf("got row %0d col %0d color %0d last %0b",
                                 got.row, got.column, got.color, got.last));
          end
        end
      end
      if (cfg_valid && cfg_ready) height_setting = cfg_data;
      if (in_tvalid && in_tready)
        rasterize_sample(in_tdata[SampleW-1:0], in_tdata[SampleW +: ColW], in_tuser);
    end
    due_count = pixel_writes_due.size();
  end

endmodule

// ===== tb/tb_top.sv =====
// Top of the rasterizer testbench: clock, reset, sample stimulus, height writes and verdict.
// Depends on wtr_pkg, waveform_trace_rasterizer and wtr_trace_checker.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import wtr_pkg::*;

  localparam int MaxWidth     = 1024;
  localparam int MaxHeight    = 64;
  localparam int CycleLimit   = 2000000;
  localparam int PhaseCount   = 8;
  localparam int PhaseSamples = 51;
  localparam int DrainCycles  = 20;

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [InDataW-1:0]   in_tdata   = '0;  // [15:0] sample, [25:16] column
  logic [ChanW-1:0]     in_tuser   = '0;  // [2:0] channel
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [OutDataW-1:0]  out_tdata;        // [5:0] row, [15:6] column, [23:16] color
  logic                 out_tlast;
  logic                 cfg_valid  = 1'b0;
  logic                 cfg_ready;
  logic [HeightW-1:0]   cfg_data   = '0;
  int                   error_count;
  int                   pending;
  int                   cycle_count = 0;
  bit                   in_calm     = 1'b0;
  bit                   out_calm    = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  waveform_trace_rasterizer #(
    .MAX_WIDTH (MaxWidth),
    .MAX_HEIGHT(MaxHeight)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  wtr_trace_checker #(
    .MAX_WIDTH (MaxWidth),
    .MAX_HEIGHT(MaxHeight)
  ) checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .error_count(error_count),
    .pending    (pending)
  );

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_sample(input logic [SampleW-1:0] sample, input logic [ColW-1:0] column,
                             input logic [ChanW-1:0] chan);
    int gap;
    if ($urandom_range(0, 15) == 0) in_calm = !in_calm;
    gap = in_calm ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tdata  <= {{(InDataW-SampleW-ColW){1'b0}}, column, sample};
    in_tuser  <= chan;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // Write only once every predicted pixel has left the block.
  task automatic write_height(input logic [HeightW-1:0] value);
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin : pixel_sink
    int stall;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if ($urandom_range(0, 15) == 0) out_calm = !out_calm;
      stall = out_calm ? 0 : $urandom_range(0, 15);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      @(negedge clk);
    end
  end

  initial begin : watchdog
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin : stimulus
    logic [SampleW-1:0] smp;
    logic [ColW-1:0]    col;
    logic [ChanW-1:0]   chan;
    int                 heights[PhaseCount];
    heights = '{64, 1, 0, 127, 37, 64, 2, 100};
    smp = '0;
    col = '0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset height: top row, full swing down, mid level, flat line, small offsets, restart.
    send_sample(16'h7FFF, 10'd0,    3'd0);
    send_sample(16'h8000, 10'd1,    3'd7);
    send_sample(16'h0000, 10'd2,    3'd1);
    send_sample(16'h0000, 10'd3,    3'd2);
    send_sample(16'h0001, 10'd4,    3'd3);
    send_sample(16'hFFFF, 10'd5,    3'd4);
    send_sample(16'h4000, 10'd6,    3'd5);
    send_sample(16'hC000, 10'd1023, 3'd6);
    send_sample(16'h8000, 10'd0,    3'd7);
    // Zero height acts as one row; the trace rises from the bottom row left behind.
    write_height(7'd0);
    send_sample(16'h8000, 10'd1,    3'd0);
    send_sample(16'h7FFF, 10'd2,    3'd1);
    // Oversized height saturates.
    write_height(7'd127);
    send_sample(16'h8000, 10'd3,    3'd2);
    send_sample(16'h0000, 10'd4,    3'd3);
    write_height(7'd1);
    send_sample(16'h1234, 10'd5,    3'd4);
    write_height(7'd5);
    send_sample(16'h8000, 10'd6,    3'd5);
    send_sample(16'h7FFF, 10'd7,    3'd6);
    write_height(7'd64);
    send_sample(16'h0000, 10'd8,    3'd7);

    // Mostly contiguous traces with occasional restarts and jumps.
    for (int p = 0; p < PhaseCount; p++) begin
      write_height(p == 5 ? HeightW'($urandom_range(1, 64)) : HeightW'(heights[p]));
      for (int i = 0; i < PhaseSamples; i++) begin
        case ($urandom_range(0, 15))
          0:       col = '0;
          1:       col = ColW'($urandom_range(0, 1023));
          default: col = col + 1'b1;
        endcase
        case ($urandom_range(0, 7))
          0: begin
            case ($urandom_range(0, 3))
              0:       smp = 16'h8000;
              1:       smp = 16'h7FFF;
              2:       smp = 16'h0000;
              default: smp = 16'hFFFF;
            endcase
          end
          1, 2, 3: smp = SampleW'($urandom());
          default: smp = smp + SampleW'($urandom_range(0, 4095)) - 16'd2048;
        endcase
        chan = ChanW'($urandom_range(0, 7));
        send_sample(smp, col, chan);
      end
    end
    in_tvalid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
